// File: src/floppy_raw_track_formatter_assert.svh
// assertion macros for the raw track formatter, compiled out for synthesis
`ifndef FLOPPY_RAW_TRACK_FORMATTER_ASSERT_SVH
`define FLOPPY_RAW_TRACK_FORMATTER_ASSERT_SVH
`ifndef SYNTHESIS
`define FRTF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FRTF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FRTF_ASSERT(label, clk, rst, prop, msg)
`define FRTF_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: src/frtf_pkg.sv
package frtf_pkg;

   localparam int POS_W  = 12;
   localparam int OFS_W  = 8;
   localparam int CNT_W  = 5;
   localparam int SUM_W  = 16;
   localparam int BYTE_W = 8;

   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [OFS_W-1:0]  ofs_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [SUM_W-1:0]  sum_type;
   typedef logic [BYTE_W-1:0] byte_type;

   localparam ofs_type HEADER_LEN   = 8'd10;
   localparam ofs_type REGION_LEN   = 8'd130;
   localparam ofs_type DATA_LEN     = 8'd128;
   localparam ofs_type SYS_FILL_LEN = 8'd80;
   localparam cnt_type CNT_MAX      = 5'd31;

   // header byte offsets
   localparam ofs_type HDR_OFS_MARK    = 8'd0;
   localparam ofs_type HDR_OFS_TRACK   = 8'd1;
   localparam ofs_type HDR_OFS_COUNT   = 8'd2;
   localparam ofs_type HDR_OFS_ZERO_A  = 8'd3;
   localparam ofs_type HDR_OFS_FIRST_L = 8'd4;
   localparam ofs_type HDR_OFS_FIRST_H = 8'd5;
   localparam ofs_type HDR_OFS_PAD     = 8'd6;
   localparam ofs_type HDR_OFS_ZERO_B  = 8'd7;
   localparam ofs_type HDR_OFS_SUM_L   = 8'd8;

   // system sector byte offsets
   localparam ofs_type SYS_OFS_MARK_A = 8'd80;
   localparam ofs_type SYS_OFS_MARK_B = 8'd81;

   localparam byte_type HDR_MARK      = 8'o363;
   localparam byte_type SYS_FILL_BYTE = 8'd23;
   localparam byte_type SYS_MARK_A    = 8'h30;
   localparam byte_type SYS_MARK_B    = 8'h07;
   localparam byte_type PAD_BYTE      = 8'hff;
   localparam byte_type ZERO_BYTE     = 8'h00;
   localparam byte_type FILL_BYTE     = 8'h4e;

endpackage

// File: src/floppy_raw_track_formatter.sv
// Raw floppy track formatter.
// Input channel req_*: one item per raw track position. req_start_req restarts
// the track at position 0 and latches req_track_number; req_sector_byte is the
// next user data byte and is consumed only where the result shows it taken.
// Result channel rsp_*: one transfer per input item, carrying the raw byte,
// rsp_data_taken and rsp_last (final position and every item beyond it).
// Latency: the result is valid the cycle after the input transfer.
// Throughput: one item per cycle while the receiver keeps up; position, offset,
// sector count and checksum change only on the edge at which an item is taken.
// A single output register sits between the channels: req_ready stays high
// while that register is empty or being emptied in the same cycle, so a
// stalled receiver holds back the input after one buffered result.
// Reset (synchronous) drops any pending result and formats track 0 from
// position 0 until the first start item arrives.
// Layout: 10-byte header, system sector on track 0, 130-byte data sectors
// (128 data bytes and a 16-bit checksum), then 0x4e fill.
`include "floppy_raw_track_formatter_assert.svh"

module floppy_raw_track_formatter #(
   parameter int RAW_TRACK_BYTES   = 3125,
   parameter int SECTORS_PER_TRACK = 23
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_start_req,
   input  logic [7:0] req_track_number,
   input  logic [7:0] req_sector_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_raw_byte,
   output logic       rsp_data_taken,
   output logic       rsp_last
);

   localparam frtf_pkg::pos_type RawEnd   = frtf_pkg::pos_type'(RAW_TRACK_BYTES);
   localparam frtf_pkg::pos_type RawFinal = frtf_pkg::pos_type'(RAW_TRACK_BYTES - 1);
   localparam frtf_pkg::pos_type LayoutEnd =
      frtf_pkg::pos_type'(10 + 130 * SECTORS_PER_TRACK);
   localparam frtf_pkg::sum_type SptWord  = frtf_pkg::sum_type'(SECTORS_PER_TRACK);
   localparam frtf_pkg::byte_type SptByte = frtf_pkg::byte_type'(SECTORS_PER_TRACK);

   frtf_pkg::pos_type  position_ff, position_in;
   frtf_pkg::ofs_type  region_offset_ff, region_offset_in;
   frtf_pkg::cnt_type  sector_count_ff, sector_count_in;
   frtf_pkg::sum_type  running_sum_ff, running_sum_in;
   frtf_pkg::byte_type held_track_ff, held_track_in;

   logic               rsp_valid_ff, rsp_valid_in;
   frtf_pkg::byte_type rsp_raw_byte_ff, rsp_raw_byte_in;
   logic               rsp_data_taken_ff, rsp_data_taken_in;
   logic               rsp_last_ff, rsp_last_in;

   frtf_pkg::pos_type  cur_pos;
   frtf_pkg::ofs_type  cur_ofs;
   frtf_pkg::cnt_type  cur_cnt;
   frtf_pkg::sum_type  cur_sum;
   frtf_pkg::byte_type cur_track;
   frtf_pkg::sum_type  first_sector;
   frtf_pkg::byte_type out_byte;
   logic               taken;
   logic               is_sum_byte;
   logic               in_header;
   logic               in_layout;
   logic               past_end;
   logic               req_xfer;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      cur_pos   = position_ff;
      cur_ofs   = region_offset_ff;
      cur_cnt   = sector_count_ff;
      cur_sum   = running_sum_ff;
      cur_track = held_track_ff;
      if (req_start_req) begin
         cur_pos   = '0;
         cur_ofs   = '0;
         cur_cnt   = '0;
         cur_sum   = '0;
         cur_track = req_track_number;
      end

      past_end     = cur_pos >= RawEnd;
      in_header    = cur_pos < frtf_pkg::pos_type'(frtf_pkg::HEADER_LEN);
      in_layout    = cur_pos < LayoutEnd;
      first_sector = frtf_pkg::sum_type'(cur_track) * SptWord;

      out_byte    = frtf_pkg::FILL_BYTE;
      taken       = 1'b0;
      is_sum_byte = 1'b0;

      if (in_header) begin
         case (cur_ofs)
            frtf_pkg::HDR_OFS_MARK:    out_byte = frtf_pkg::HDR_MARK;
            frtf_pkg::HDR_OFS_TRACK:   out_byte = cur_track;
            frtf_pkg::HDR_OFS_COUNT:   out_byte = SptByte;
            frtf_pkg::HDR_OFS_ZERO_A:  out_byte = frtf_pkg::ZERO_BYTE;
            frtf_pkg::HDR_OFS_FIRST_L: out_byte = first_sector[7:0];
            frtf_pkg::HDR_OFS_FIRST_H: out_byte = first_sector[15:8];
            frtf_pkg::HDR_OFS_PAD:     out_byte = frtf_pkg::PAD_BYTE;
            frtf_pkg::HDR_OFS_ZERO_B:  out_byte = frtf_pkg::ZERO_BYTE;
            frtf_pkg::HDR_OFS_SUM_L: begin
               out_byte    = cur_sum[7:0];
               is_sum_byte = 1'b1;
            end
            default: begin
               out_byte    = cur_sum[15:8];
               is_sum_byte = 1'b1;
            end
         endcase
      end else if (in_layout) begin
         if (cur_ofs < frtf_pkg::DATA_LEN) begin
            // track 0 carries the fixed system sector in the first region
            if (cur_track == '0 && cur_cnt == '0) begin
               if (cur_ofs < frtf_pkg::SYS_FILL_LEN) begin
                  out_byte = frtf_pkg::SYS_FILL_BYTE;
               end else if (cur_ofs == frtf_pkg::SYS_OFS_MARK_A) begin
                  out_byte = frtf_pkg::SYS_MARK_A;
               end else if (cur_ofs == frtf_pkg::SYS_OFS_MARK_B) begin
                  out_byte = frtf_pkg::SYS_MARK_B;
               end else begin
                  out_byte = frtf_pkg::PAD_BYTE;
               end
            end else begin
               out_byte = req_sector_byte;
               taken    = 1'b1;
            end
         end else if (cur_ofs == frtf_pkg::DATA_LEN) begin
            out_byte    = cur_sum[7:0];
            is_sum_byte = 1'b1;
         end else begin
            out_byte    = cur_sum[15:8];
            is_sum_byte = 1'b1;
         end
      end

      position_in      = cur_pos;
      region_offset_in = cur_ofs;
      sector_count_in  = cur_cnt;
      running_sum_in   = cur_sum;
      held_track_in    = cur_track;

      if (!past_end) begin
         position_in = cur_pos + 1'b1;
         if (in_layout) begin
            if (!is_sum_byte) begin
               running_sum_in = cur_sum + {{8{out_byte[7]}}, out_byte};
            end
            if (in_header && cur_ofs >= frtf_pkg::HEADER_LEN - 1'b1) begin
               region_offset_in = '0;
               running_sum_in   = '0;
            end else if (!in_header && cur_ofs >= frtf_pkg::REGION_LEN - 1'b1) begin
               region_offset_in = '0;
               running_sum_in   = '0;
               if (cur_cnt < frtf_pkg::CNT_MAX) begin
                  sector_count_in = cur_cnt + 1'b1;
               end
            end else begin
               region_offset_in = cur_ofs + 1'b1;
            end
         end
      end

      rsp_raw_byte_in   = past_end ? frtf_pkg::FILL_BYTE : out_byte;
      rsp_data_taken_in = !past_end && taken;
      rsp_last_in       = cur_pos >= RawFinal;
      rsp_valid_in      = req_xfer || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff      <= '0;
         region_offset_ff <= '0;
         sector_count_ff  <= '0;
         running_sum_ff   <= '0;
         held_track_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            position_ff      <= position_in;
            region_offset_ff <= region_offset_in;
            sector_count_ff  <= sector_count_in;
            running_sum_ff   <= running_sum_in;
            held_track_ff    <= held_track_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_raw_byte_ff   <= rsp_raw_byte_in;
         rsp_data_taken_ff <= rsp_data_taken_in;
         rsp_last_ff       <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_raw_byte   = rsp_raw_byte_ff;
   assign rsp_data_taken = rsp_data_taken_ff;
   assign rsp_last       = rsp_last_ff;

   // header offset follows the position exactly
   `FRTF_ASSERT(a_header_offset, clock, reset, (position_ff < frtf_pkg::pos_type'(frtf_pkg::HEADER_LEN) |-> frtf_pkg::pos_type'(region_offset_ff) == position_ff), "header offset out of step with position")
   // once the layout is done the region state stays cleared
   `FRTF_ASSERT(a_fill_clean, clock, reset, (position_ff >= LayoutEnd |-> region_offset_ff == '0 && running_sum_ff == '0), "region state not cleared after layout")
   `FRTF_ASSERT(a_pos_sat, clock, reset, (position_ff <= RawEnd), "position beyond track end")
   `FRTF_ASSERT(a_taken_not_last, clock, reset, (rsp_valid_ff && rsp_data_taken_ff |-> !rsp_last_ff), "data taken at final position")
   `FRTF_ASSERT(a_stall_blocks, clock, reset, (rsp_valid_ff && !rsp_ready |-> !req_ready), "input taken while result stalled")

endmodule

// File: tb/sv/floppy_raw_track_formatter_tb.sv
module floppy_raw_track_formatter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RAW_BYTES     = 3125;
   localparam int SECTORS       = 23;
   localparam int MAX_GAP       = 10;
   localparam int RANDOM_ITEMS  = 400;
   localparam int TAIL_CYCLES   = 16;

   typedef struct packed {
      logic               start;
      frtf_pkg::byte_type trk;
      frtf_pkg::byte_type data;
      logic               hold_off;
   } feed_item_type;

   typedef struct packed {
      logic [31:0]        idx;
      frtf_pkg::byte_type raw;
      logic               taken;
      logic               last;
   } track_byte_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_start_req = 1'b0;
   frtf_pkg::byte_type req_track_number = '0;
   frtf_pkg::byte_type req_sector_byte = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   frtf_pkg::byte_type rsp_raw_byte;
   logic               rsp_data_taken;
   logic               rsp_last;

   feed_item_type  track_feed[$];
   track_byte_type expected_bytes[$];

   // formatter state as the predictor sees it
   frtf_pkg::pos_type  fmt_pos = '0;
   frtf_pkg::ofs_type  fmt_ofs = '0;
   frtf_pkg::cnt_type  fmt_regions = '0;
   frtf_pkg::sum_type  fmt_sum = '0;
   frtf_pkg::byte_type fmt_track = '0;

   int unsigned n_errors = 0;
   int unsigned n_total = 0;
   int unsigned n_accepted = 0;
   int unsigned n_results = 0;
   int unsigned n_starts = 0;
   int unsigned n_taken = 0;
   int unsigned n_last = 0;
   int unsigned cycles = 0;
   int unsigned cycle_limit = 32'hffff_ffff;
   int unsigned tx_wait = 0;
   int unsigned rx_wait = 0;
   bit          tx_calm = 1'b0;
   bit          rx_calm = 1'b1;

   floppy_raw_track_formatter #(
      .RAW_TRACK_BYTES  (RAW_BYTES),
      .SECTORS_PER_TRACK(SECTORS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_start_req   (req_start_req),
      .req_track_number(req_track_number),
      .req_sector_byte (req_sector_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_raw_byte    (rsp_raw_byte),
      .rsp_data_taken  (rsp_data_taken),
      .rsp_last        (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
   end

   // idle length per transfer; calm stretches give back-to-back traffic
   function automatic int unsigned pause_len(inout bit calm);
      if ($urandom_range(0, 47) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic track_byte_type format_next(logic start, frtf_pkg::byte_type trk,
                                                  frtf_pkg::byte_type data);
      track_byte_type r;
      logic [15:0]    first;
      logic           in_hdr;
      logic           is_sum;
      int             layout_end;
      layout_end = int'(frtf_pkg::HEADER_LEN) + int'(frtf_pkg::REGION_LEN) * SECTORS;
      if (start) begin
         fmt_pos = '0;
         fmt_ofs = '0;
         fmt_regions = '0;
         fmt_sum = '0;
         fmt_track = trk;
      end
      r.idx = n_accepted;
      r.raw = frtf_pkg::FILL_BYTE;
      r.taken = 1'b0;
      r.last = 1'b1;
      // past the end of the track nothing moves
      if (int'(fmt_pos) >= RAW_BYTES) return r;
      r.last = (int'(fmt_pos) == RAW_BYTES - 1);
      in_hdr = (int'(fmt_pos) < int'(frtf_pkg::HEADER_LEN));
      is_sum = 1'b0;
      if (in_hdr) begin
         first = 16'(int'(fmt_track) * SECTORS);
         case (fmt_ofs)
            frtf_pkg::HDR_OFS_MARK:    r.raw = frtf_pkg::HDR_MARK;
            frtf_pkg::HDR_OFS_TRACK:   r.raw = fmt_track;
            frtf_pkg::HDR_OFS_COUNT:   r.raw = 8'(SECTORS);
            frtf_pkg::HDR_OFS_ZERO_A:  r.raw = frtf_pkg::ZERO_BYTE;
            frtf_pkg::HDR_OFS_FIRST_L: r.raw = first[7:0];
            frtf_pkg::HDR_OFS_FIRST_H: r.raw = first[15:8];
            frtf_pkg::HDR_OFS_PAD:     r.raw = frtf_pkg::PAD_BYTE;
            frtf_pkg::HDR_OFS_ZERO_B:  r.raw = frtf_pkg::ZERO_BYTE;
            frtf_pkg::HDR_OFS_SUM_L: begin
               r.raw = fmt_sum[7:0];
               is_sum = 1'b1;
            end
            default: begin
               r.raw = fmt_sum[15:8];
               is_sum = 1'b1;
            end
         endcase
      end else if (int'(fmt_pos) < layout_end) begin
         if (fmt_ofs < frtf_pkg::DATA_LEN) begin
            // first region of track 0 is the fixed system sector
            if (fmt_track == 8'd0 && fmt_regions == '0) begin
               if (fmt_ofs < frtf_pkg::SYS_FILL_LEN) r.raw = frtf_pkg::SYS_FILL_BYTE;
               else if (fmt_ofs == frtf_pkg::SYS_OFS_MARK_A) r.raw = frtf_pkg::SYS_MARK_A;
               else if (fmt_ofs == frtf_pkg::SYS_OFS_MARK_B) r.raw = frtf_pkg::SYS_MARK_B;
               else r.raw = frtf_pkg::PAD_BYTE;
            end else begin
               r.raw = data;
               r.taken = 1'b1;
            end
         end else if (fmt_ofs == frtf_pkg::DATA_LEN) begin
            r.raw = fmt_sum[7:0];
            is_sum = 1'b1;
         end else begin
            r.raw = fmt_sum[15:8];
            is_sum = 1'b1;
         end
      end
      if (int'(fmt_pos) < layout_end) begin
         if (!is_sum) fmt_sum = fmt_sum + {{8{r.raw[7]}}, r.raw};
         if (in_hdr && int'(fmt_ofs) >= int'(frtf_pkg::HEADER_LEN) - 1) begin
            fmt_ofs = '0;
            fmt_sum = '0;
         end else if (!in_hdr && int'(fmt_ofs) >= int'(frtf_pkg::REGION_LEN) - 1) begin
            fmt_ofs = '0;
            fmt_sum = '0;
            if (fmt_regions < frtf_pkg::CNT_MAX) fmt_regions = fmt_regions + 1'b1;
         end else begin
            fmt_ofs = fmt_ofs + 1'b1;
         end
      end
      fmt_pos = fmt_pos + 1'b1;
      return r;
   endfunction

   task automatic report_mismatch(string what, int unsigned idx, int got, int want);
      $display("mismatch: %s, item %0d: got %0h, want %0h", what, idx, got, want);
      n_errors++;
   endtask

   task automatic push_item(logic start, frtf_pkg::byte_type trk, frtf_pkg::byte_type data,
                            logic hold);
      feed_item_type it;
      it.start = start;
      it.trk = trk;
      it.data = data;
      it.hold_off = hold;
      track_feed.push_back(it);
      n_total++;
   endtask

   // one start transfer then len-1 plain positions with random payload
   task automatic queue_track(frtf_pkg::byte_type trk, int unsigned len, logic hold);
      push_item(1'b1, trk, 8'($urandom), hold);
      for (int unsigned i = 1; i < len; i++)
         push_item(1'b0, 8'($urandom), 8'($urandom), 1'b0);
   endtask

   always @(posedge clock) begin : driver
      feed_item_type nxt;
      logic          fire;
      fire = req_valid && req_ready;
      if (reset) begin
         req_valid <= 1'b0;
         req_start_req <= 1'b0;
         req_track_number <= '0;
         req_sector_byte <= '0;
      end else if (!req_valid || fire) begin
         if (fire) tx_wait = pause_len(tx_calm);
         if (tx_wait != 0) begin
            tx_wait--;
            req_valid <= 1'b0;
         end else if (track_feed.size() != 0 &&
                      !(track_feed[0].hold_off && (fire || expected_bytes.size() != 0))) begin
            nxt = track_feed.pop_front();
            req_valid <= 1'b1;
            req_start_req <= nxt.start;
            req_track_number <= nxt.trk;
            req_sector_byte <= nxt.data;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) rx_wait = pause_len(rx_calm);
         if (rx_wait != 0) begin
            rx_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : monitor
      track_byte_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            want = format_next(req_start_req, req_track_number, req_sector_byte);
            expected_bytes.push_back(want);
            n_accepted++;
            if (req_start_req) n_starts++;
            if (want.taken) n_taken++;
            if (want.last) n_last++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch("result transfer with nothing pending", n_results,
                               rsp_raw_byte, 0);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_raw_byte !== want.raw)
                  report_mismatch("raw_byte", want.idx, rsp_raw_byte, want.raw);
               if (rsp_data_taken !== want.taken)
                  report_mismatch("data_taken", want.idx, rsp_data_taken, want.taken);
               if (rsp_last !== want.last)
                  report_mismatch("last", want.idx, rsp_last, want.last);
            end
            n_results++;
         end
      end
   end

   initial begin
      int unsigned        random_items;
      int unsigned        len;
      int unsigned        pick;
      frtf_pkg::byte_type trk;
      bit                 timed_out;

      // no start since reset: track 0 from position 0, track number ignored
      for (int i = 0; i < 4; i++)
         push_item(1'b0, 8'($urandom), 8'($urandom), 1'b0);
      // highest track: header then data bytes at the extremes
      push_item(1'b1, 8'hff, 8'h00, 1'b1);
      for (int i = 0; i < 9; i++)
         push_item(1'b0, 8'h00, 8'($urandom), 1'b0);
      push_item(1'b0, 8'hff, 8'h00, 1'b0);
      push_item(1'b0, 8'h5a, 8'hff, 1'b0);
      push_item(1'b0, 8'ha5, 8'h80, 1'b0);
      push_item(1'b0, 8'h00, 8'h7f, 1'b0);
      // back-to-back starts
      push_item(1'b1, 8'h00, 8'h00, 1'b0);
      push_item(1'b1, 8'h01, 8'hff, 1'b0);
      push_item(1'b1, 8'h80, 8'h55, 1'b0);
      push_item(1'b0, 8'h7f, 8'haa, 1'b0);

      // a whole track 0 running past the end: system sector, all data sectors, fill
      queue_track(8'h00, RAW_BYTES + 6, 1'b1);

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 3) trk = 8'h00;
         else if (pick == 3) trk = 8'hff;
         else trk = 8'($urandom);
         pick = $urandom_range(0, 9);
         // short runs end within the header or first sector
         if (pick < 6) len = $urandom_range(1, 140);
         else len = $urandom_range(141, 300);
         queue_track(trk, len, $urandom_range(0, 7) == 0);
         random_items += len;
      end

      cycle_limit = n_total * (2 * MAX_GAP + 4) * 4 + 2000;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (!(n_accepted == n_total && expected_bytes.size() == 0) && cycles < cycle_limit)
         @(posedge clock);
      timed_out = (cycles >= cycle_limit);
      if (!timed_out) repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d items and %0d results over %0d track starts in %0d cycles",
               n_accepted, n_results, n_starts, cycles);
      $display("%0d data bytes taken, %0d results at or past the track end, %0d mismatches",
               n_taken, n_last, n_errors);
      if (n_errors == 0 && !timed_out && expected_bytes.size() == 0)
         $display("** floppy_raw_track_formatter: PASSED **");
      else
         $display("** floppy_raw_track_formatter: FAILED **");
      $finish;
   end

endmodule
